// ----- rtl/core/rwt_pkg.sv -----
// Shared types and constants of the retransmit window table.
package rwt_pkg;

  localparam int unsigned RWT_SLOTS       = 8;
  localparam int unsigned OPCODE_W        = 3;
  localparam int unsigned SLOT_W          = 3;
  localparam int unsigned ID_W            = 32;
  localparam int unsigned TYPE_W          = 5;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned WAKE_W          = 16;
  localparam int unsigned TIMEOUT_W       = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd2;
  localparam logic [WAKE_W-1:0]    WAKE_MAX    = 16'hFFFF;
  localparam logic [WAKE_W-1:0]    WAKE_MIN    = 16'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET_FREE      = 3'd0,
    OP_MARK_RECV     = 3'd1,
    OP_MARK_SENT     = 3'd2,
    OP_DELETE        = 3'd3,
    OP_PURGE_ACK     = 3'd4,
    OP_SEND_PICK     = 3'd5,
    OP_SCHEDULE_NOW  = 3'd6,
    OP_GET_SEQUENCED = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPSCAN,
    ST_APPLY,
    ST_STSCAN,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic op_scan;
    logic apply;
    logic st_scan;
    logic rd_en;
  } cmd_t;

endpackage

// ----- rtl/core/rwt_req_if.sv -----
// Request channel: one table operation per transaction.
interface rwt_req_if
  import rwt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SLOT_W-1:0]   slot;
  logic [ID_W-1:0]     id_in;
  logic [TYPE_W-1:0]   type_in;
  logic                bump_sequence;
  logic [TIME_W-1:0]   now;

  modport source (
    output valid, opcode, slot, id_in, type_in, bump_sequence, now,
    input  ready
  );

  modport sink (
    input  valid, opcode, slot, id_in, type_in, bump_sequence, now,
    output ready
  );
endinterface

// ----- rtl/core/rwt_rsp_if.sv -----
// Response channel: the result and table status of one operation.
interface rwt_rsp_if
  import rwt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] slot_out;
  logic [ID_W-1:0]   id_out;
  logic [TYPE_W-1:0] type_out;
  logic [WAKE_W-1:0] wake_seconds;
  logic              all_empty;
  logic              free_available;
  logic              send_ready;

  modport source (
    output valid, found, slot_out, id_out, type_out, wake_seconds, all_empty,
           free_available, send_ready,
    input  ready
  );

  modport sink (
    input  valid, found, slot_out, id_out, type_out, wake_seconds, all_empty,
           free_available, send_ready,
    output ready
  );
endinterface

// ----- rtl/core/retransmit_window_table.sv -----
// Top level of the retransmit window table.
//
// Usage: one operation enters per transaction on req (opcode, slot, id_in,
// type_in, bump_sequence, now); exactly one transaction leaves on rsp with
// the operation's result and the table status after it. The user must write
// the retry timeout through cfg_we_i/cfg_data_i while no operation is in
// flight; the block itself does not enforce this.
//
// Timing: an operation scans the slot memory once for its search, performs
// the update in the APPLY state and scans it again for the status, one slot
// per cycle through the single read port of the slot memories. rsp.valid
// rises in the RESP state after the status scan, and the next request can
// be accepted in the cycle after the response is taken.
//
// Reset clears all active and armed flags and the sequence number and sets
// the retry timeout to 2; no clearing pass is needed. While rsp is stalled,
// the response is held unchanged and req.ready stays low.
module retransmit_window_table
  import rwt_pkg::*;
#(
  parameter int unsigned SLOTS = RWT_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rwt_req_if.sink              req,
  rwt_rsp_if.source            rsp,
  input  logic                 cfg_we_i,
  input  logic [TIMEOUT_W-1:0] cfg_data_i
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cmd_t          cmd;
  logic [SW-1:0] rd_addr;

  rwt_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  rwt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (req.opcode),
    .slot_i           (req.slot),
    .id_in_i          (req.id_in),
    .type_in_i        (req.type_in),
    .bump_sequence_i  (req.bump_sequence),
    .now_i            (req.now),
    .found_o          (rsp.found),
    .slot_out_o       (rsp.slot_out),
    .id_out_o         (rsp.id_out),
    .type_out_o       (rsp.type_out),
    .wake_seconds_o   (rsp.wake_seconds),
    .all_empty_o      (rsp.all_empty),
    .free_available_o (rsp.free_available),
    .send_ready_o     (rsp.send_ready)
  );

endmodule

// ----- rtl/core/rwt_ctrl.sv -----
// Controller of the retransmit window table: sequencing of scans and update.
module rwt_ctrl
  import rwt_pkg::*;
#(
  parameter  int unsigned SLOTS = RWT_SLOTS,
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned CW    = $clog2(SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output cmd_t          cmd_o,
  output logic [SW-1:0] rd_addr_o
);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          scan_last;
  logic          in_scan;

  assign scan_last = (cnt_q == CW'(SLOTS));
  assign in_scan   = (state_q == ST_OPSCAN) || (state_q == ST_STSCAN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_OPSCAN;
      end
      ST_OPSCAN: begin
        if (scan_last) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        state_d = ST_STSCAN;
      end
      ST_STSCAN: begin
        if (scan_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    req_ready_o   = 1'b0;
    rsp_valid_o   = 1'b0;
    cmd_o.rd_en   = in_scan && !scan_last;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.start = req_valid_i;
      end
      ST_OPSCAN: begin
        cmd_o.op_scan = 1'b1;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
      end
      ST_STSCAN: begin
        cmd_o.st_scan = 1'b1;
      end
      ST_RESP: begin
        rsp_valid_o = 1'b1;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  assign rd_addr_o = cnt_q[SW-1:0];

  // The read counter runs one past the last slot so the final read data is seen.
  always_comb begin
    cnt_d = cnt_q;
    if (!in_scan) begin
      cnt_d = '0;
    end else if (!scan_last) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == ST_OPSCAN && cnt_q == '0))
    else $error("accepted transaction did not start the operation scan");

  a_apply_then_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> (state_q == ST_STSCAN && cnt_q == '0))
    else $error("update was not followed by a fresh status scan");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (cnt_q < CW'(SLOTS)))
    else $error("table read beyond the last slot");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (!req_ready_o && !cmd_o.rd_en))
    else $error("new request or scan while a response is pending");
`endif

endmodule

// ----- rtl/core/rwt_dp.sv -----
// Datapath of the retransmit window table: slot memories, flags and accumulators.
module rwt_dp
  import rwt_pkg::*;
#(
  parameter  int unsigned SLOTS = RWT_SLOTS,
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [SW-1:0]        rd_addr_i,
  input  logic                 cfg_we_i,
  input  logic [TIMEOUT_W-1:0] cfg_data_i,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [ID_W-1:0]      id_in_i,
  input  logic [TYPE_W-1:0]    type_in_i,
  input  logic                 bump_sequence_i,
  input  logic [TIME_W-1:0]    now_i,
  output logic                 found_o,
  output logic [SLOT_W-1:0]    slot_out_o,
  output logic [ID_W-1:0]      id_out_o,
  output logic [TYPE_W-1:0]    type_out_o,
  output logic [WAKE_W-1:0]    wake_seconds_o,
  output logic                 all_empty_o,
  output logic                 free_available_o,
  output logic                 send_ready_o
);

  // Captured request.
  opcode_e           op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ID_W-1:0]   id_in_q;
  logic [TYPE_W-1:0] type_in_q;
  logic              bump_q;
  logic [TIME_W-1:0] now_q;

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [ID_W-1:0]      nseq_q;
  logic [SLOTS-1:0]     active_q;
  logic [SLOTS-1:0]     armed_q;

  logic [ID_W-1:0]   id_mem   [SLOTS];
  logic [TYPE_W-1:0] type_mem [SLOTS];
  logic [TIME_W-1:0] nt_mem   [SLOTS];

  logic [ID_W-1:0]   rd_id_q;
  logic [TYPE_W-1:0] rd_type_q;
  logic [TIME_W-1:0] rd_nt_q;
  logic [SW-1:0]     rd_idx_q;
  logic              rd_vld_q;

  // Operation scan accumulators.
  logic              acc_found_q;
  logic [SW-1:0]     acc_idx_q;
  logic [ID_W-1:0]   acc_id_q;
  logic [TYPE_W-1:0] acc_type_q;
  logic [ID_W-1:0]   sel_id_q;

  // Result and status registers.
  logic              found_q;
  logic [SLOT_W-1:0] slot_out_q;
  logic [ID_W-1:0]   id_out_q;
  logic [TYPE_W-1:0] type_out_q;
  logic [WAKE_W-1:0] wake_q;
  logic              empty_q;
  logic              free_q;
  logic              ready_q;

  logic [SW+2:0]     slot_ext;
  logic [SW+2:0]     idx_ext;
  logic [SW-1:0]     s_addr;
  logic              slot_ok;
  logic              cur_act;
  logic              cur_armed;
  logic              due;
  logic              take;
  logic              op_eval;
  logic              st_eval;
  logic [TIME_W-1:0] diff;
  logic [WAKE_W-1:0] w;
  logic              reports_slot;

  logic              wr_rec;
  logic              wr_nt;
  logic [SW-1:0]     wr_addr;
  logic [TIME_W-1:0] wr_nt_data;
  logic [ID_W-1:0]   wr_id_data;

  assign slot_ext = (SW + 3)'(slot_q);
  assign s_addr   = slot_ext[SW-1:0];
  assign slot_ok  = (slot_ext < (SW + 3)'(SLOTS));
  assign idx_ext  = (SW + 3)'(acc_idx_q);

  assign cur_act   = active_q[rd_idx_q];
  assign cur_armed = armed_q[rd_idx_q];
  assign due       = (now_q >= rd_nt_q);
  assign op_eval   = cmd_i.op_scan && rd_vld_q;
  assign st_eval   = cmd_i.st_scan && rd_vld_q;

  // Time left until the slot is due, at least one and saturated to the field.
  assign diff = rd_nt_q - now_q;
  always_comb begin
    if (due) begin
      w = WAKE_MIN;
    end else if (|diff[TIME_W-1:WAKE_W]) begin
      w = WAKE_MAX;
    end else begin
      w = diff[WAKE_W-1:0];
    end
  end

  always_comb begin
    case (op_q)
      OP_GET_FREE:      take = !acc_found_q && !cur_act;
      OP_PURGE_ACK:     take = !acc_found_q && cur_act && (rd_id_q == id_in_q);
      OP_GET_SEQUENCED: take = !acc_found_q && cur_act && (rd_id_q == nseq_q);
      OP_SEND_PICK:     take = cur_act && due && (!acc_found_q || rd_id_q < acc_id_q);
      default:          take = 1'b0;
    endcase
  end

  assign reports_slot = (op_q == OP_GET_FREE) || (op_q == OP_SEND_PICK) ||
                        (op_q == OP_GET_SEQUENCED);

  // One write port shared by the mark update, the pick re-arm and schedule-now.
  always_comb begin
    wr_rec     = 1'b0;
    wr_nt      = 1'b0;
    wr_addr    = s_addr;
    wr_nt_data = '0;
    wr_id_data = (op_q == OP_MARK_SENT) ? nseq_q : id_in_q;
    if (op_eval && op_q == OP_SCHEDULE_NOW && cur_act) begin
      wr_nt      = 1'b1;
      wr_addr    = rd_idx_q;
      wr_nt_data = now_q;
    end else if (cmd_i.apply && slot_ok &&
                 (op_q == OP_MARK_RECV || op_q == OP_MARK_SENT)) begin
      wr_rec = 1'b1;
      wr_nt  = 1'b1;
    end else if (cmd_i.apply && op_q == OP_SEND_PICK && acc_found_q) begin
      wr_nt      = 1'b1;
      wr_addr    = acc_idx_q;
      wr_nt_data = now_q + TIME_W'(timeout_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_rec) begin
      id_mem[wr_addr]   <= wr_id_data;
      type_mem[wr_addr] <= type_in_q;
    end
    if (wr_nt) begin
      nt_mem[wr_addr] <= wr_nt_data;
    end
    if (cmd_i.rd_en) begin
      rd_id_q   <= id_mem[rd_addr_i];
      rd_type_q <= type_mem[rd_addr_i];
      rd_nt_q   <= nt_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      timeout_q <= TIMEOUT_RST;
      nseq_q    <= '0;
      active_q  <= '0;
      armed_q   <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_idx_q <= rd_addr_i;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (cmd_i.apply) begin
        case (op_q)
          OP_MARK_RECV: begin
            if (slot_ok) begin
              active_q[s_addr] <= (id_in_q >= nseq_q);
              armed_q[s_addr]  <= 1'b0;
            end
          end
          OP_MARK_SENT: begin
            if (slot_ok) begin
              active_q[s_addr] <= 1'b1;
              armed_q[s_addr]  <= 1'b0;
              nseq_q           <= nseq_q + ID_W'(1);
            end
          end
          OP_DELETE: begin
            if (slot_ok) begin
              active_q[s_addr] <= 1'b0;
              if (bump_q) nseq_q <= sel_id_q + ID_W'(1);
            end
          end
          OP_PURGE_ACK: begin
            if (acc_found_q) active_q[acc_idx_q] <= 1'b0;
          end
          OP_SEND_PICK: begin
            if (acc_found_q) armed_q[acc_idx_q] <= 1'b1;
          end
          OP_SCHEDULE_NOW: begin
            armed_q <= armed_q | active_q;
          end
          default: begin
            armed_q <= armed_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q        <= opcode_e'(opcode_i);
      slot_q      <= slot_i;
      id_in_q     <= id_in_i;
      type_in_q   <= type_in_i;
      bump_q      <= bump_sequence_i;
      now_q       <= now_i;
      acc_found_q <= 1'b0;
      empty_q     <= 1'b1;
      free_q      <= 1'b0;
      ready_q     <= 1'b0;
      wake_q      <= '0;
    end
    if (op_eval) begin
      if (take) begin
        acc_found_q <= 1'b1;
        acc_idx_q   <= rd_idx_q;
        acc_id_q    <= rd_id_q;
        acc_type_q  <= rd_type_q;
      end
      if (rd_idx_q == s_addr) begin
        sel_id_q <= rd_id_q;
      end
    end
    if (cmd_i.apply) begin
      found_q    <= reports_slot && acc_found_q;
      slot_out_q <= (reports_slot && acc_found_q) ? idx_ext[SLOT_W-1:0] : '0;
      if (acc_found_q && (op_q == OP_SEND_PICK || op_q == OP_GET_SEQUENCED)) begin
        id_out_q   <= acc_id_q;
        type_out_q <= acc_type_q;
      end else if (op_q == OP_MARK_SENT && slot_ok) begin
        id_out_q   <= nseq_q;
        type_out_q <= '0;
      end else begin
        id_out_q   <= '0;
        type_out_q <= '0;
      end
    end
    if (st_eval) begin
      if (!cur_act) begin
        free_q <= 1'b1;
      end else begin
        empty_q <= 1'b0;
        if (due) ready_q <= 1'b1;
        if (cur_armed && (wake_q == '0 || w < wake_q)) wake_q <= w;
      end
    end
  end

  assign found_o          = found_q;
  assign slot_out_o       = slot_out_q;
  assign id_out_o         = id_out_q;
  assign type_out_o       = type_out_q;
  assign wake_seconds_o   = wake_q;
  assign all_empty_o      = empty_q;
  assign free_available_o = free_q;
  assign send_ready_o     = ready_q;

endmodule

// ----- tb/retransmit_window_checker.sv -----
// Scoreboard that predicts and checks every response of the window table.
`timescale 1ns / 1ps

module retransmit_window_checker
  import rwt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rwt_req_if                   req,
  rwt_rsp_if                   rsp,
  input  logic                 cfg_we_i,
  input  logic [TIMEOUT_W-1:0] cfg_data_i,
  output int unsigned          error_count_o,
  output int unsigned          results_owed_o
);

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot_out;
    logic [ID_W-1:0]   id_out;
    logic [TYPE_W-1:0] type_out;
    logic [WAKE_W-1:0] wake_seconds;
    logic              all_empty;
    logic              free_available;
    logic              send_ready;
  } table_result_t;

  // Shadow copy of the slot table and its registers.
  logic                 slot_live  [RWT_SLOTS];
  logic [ID_W-1:0]      slot_pkt_id[RWT_SLOTS];
  logic [TYPE_W-1:0]    slot_kind  [RWT_SLOTS];
  logic [TIME_W-1:0]    slot_due   [RWT_SLOTS];
  logic                 slot_armed [RWT_SLOTS];
  logic [ID_W-1:0]      next_seq;
  logic [TIMEOUT_W-1:0] retry_timeout_q;

  table_result_t pending_results[$];
  table_result_t got;
  table_result_t want;

  function automatic table_result_t apply_table_op(
    input opcode_e           op,
    input logic [SLOT_W-1:0] s,
    input logic [ID_W-1:0]   id_v,
    input logic [TYPE_W-1:0] type_v,
    input logic              bump,
    input logic [TIME_W-1:0] now_v
  );
    table_result_t     r;
    int                best;
    logic              hit;
    logic [TIME_W-1:0] gap;
    logic [WAKE_W-1:0] w;
    r = '0;
    r.all_empty = 1'b1;
    best = -1;
    hit = 1'b0;
    case (op)
      OP_GET_FREE: begin
        for (int i = 0; i < RWT_SLOTS; i++) begin
          if (!slot_live[i] && !hit) begin
            hit = 1'b1;
            r.slot_out = SLOT_W'(i);
          end
        end
        r.found = hit;
      end
      OP_MARK_RECV: begin
        // The id is stored even when it falls below the sequence number.
        slot_pkt_id[s] = id_v;
        slot_live[s]   = (id_v >= next_seq);
        slot_kind[s]   = type_v;
        slot_due[s]    = '0;
        slot_armed[s]  = 1'b0;
      end
      OP_MARK_SENT: begin
        r.id_out       = next_seq;
        slot_pkt_id[s] = next_seq;
        slot_live[s]   = 1'b1;
        slot_kind[s]   = type_v;
        slot_due[s]    = '0;
        slot_armed[s]  = 1'b0;
        next_seq       = next_seq + 1;
      end
      OP_DELETE: begin
        slot_live[s] = 1'b0;
        if (bump) begin
          next_seq = slot_pkt_id[s] + 1;
        end
      end
      OP_PURGE_ACK: begin
        for (int i = 0; i < RWT_SLOTS; i++) begin
          if (slot_live[i] && slot_pkt_id[i] == id_v && !hit) begin
            hit = 1'b1;
            slot_live[i] = 1'b0;
          end
        end
      end
      OP_SEND_PICK: begin
        // Strict compare keeps the lowest index among equal ids.
        for (int i = 0; i < RWT_SLOTS; i++) begin
          if (slot_live[i] && now_v >= slot_due[i]) begin
            if (best < 0 || slot_pkt_id[i] < slot_pkt_id[best]) begin
              best = i;
            end
          end
        end
        if (best >= 0) begin
          slot_due[best]   = now_v + TIME_W'(retry_timeout_q);
          slot_armed[best] = 1'b1;
          r.found          = 1'b1;
          r.slot_out       = SLOT_W'(best);
          r.id_out         = slot_pkt_id[best];
          r.type_out       = slot_kind[best];
        end
      end
      OP_SCHEDULE_NOW: begin
        for (int i = 0; i < RWT_SLOTS; i++) begin
          if (slot_live[i]) begin
            slot_due[i]   = now_v;
            slot_armed[i] = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < RWT_SLOTS; i++) begin
          if (slot_live[i] && slot_pkt_id[i] == next_seq && !hit) begin
            hit        = 1'b1;
            r.found    = 1'b1;
            r.slot_out = SLOT_W'(i);
            r.id_out   = slot_pkt_id[i];
            r.type_out = slot_kind[i];
          end
        end
      end
    endcase

    for (int i = 0; i < RWT_SLOTS; i++) begin
      if (!slot_live[i]) begin
        r.free_available = 1'b1;
      end else begin
        r.all_empty = 1'b0;
        if (now_v >= slot_due[i]) begin
          r.send_ready = 1'b1;
        end
        if (slot_armed[i]) begin
          if (slot_due[i] <= now_v) begin
            w = WAKE_MIN;
          end else begin
            gap = slot_due[i] - now_v;
            w = (gap > TIME_W'(WAKE_MAX)) ? WAKE_MAX : gap[WAKE_W-1:0];
          end
          if (r.wake_seconds == '0 || w < r.wake_seconds) begin
            r.wake_seconds = w;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RWT_SLOTS; i++) begin
        slot_live[i]   = 1'b0;
        slot_pkt_id[i] = '0;
        slot_kind[i]   = '0;
        slot_due[i]    = '0;
        slot_armed[i]  = 1'b0;
      end
      next_seq        = '0;
      retry_timeout_q = TIMEOUT_RST;
      pending_results.delete();
      error_count_o   = 0;
      results_owed_o  = 0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        retry_timeout_q = cfg_data_i;
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got.found          = rsp.found;
        got.slot_out       = rsp.slot_out;
        got.id_out         = rsp.id_out;
        got.type_out       = rsp.type_out;
        got.wake_seconds   = rsp.wake_seconds;
        got.all_empty      = rsp.all_empty;
        got.free_available = rsp.free_available;
        got.send_ready     = rsp.send_ready;
        if (pending_results.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10) begin
            $display("%0t: response transaction with no request outstanding", $realtime);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            error_count_o++;
            if (error_count_o <= 10) begin
              $display("%0t: response mismatch", $realtime);
              $display("  expected found=%b slot=%0d id=%h type=%0d wake=%0d empty=%b free=%b ready=%b",
                       want.found, want.slot_out, want.id_out, want.type_out,
                       want.wake_seconds, want.all_empty, want.free_available,
                       want.send_ready);
              $display("  actual   found=%b slot=%0d id=%h type=%0d wake=%0d empty=%b free=%b ready=%b",
                       got.found, got.slot_out, got.id_out, got.type_out,
                       got.wake_seconds, got.all_empty, got.free_available,
                       got.send_ready);
            end
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        pending_results.push_back(apply_table_op(opcode_e'(req.opcode), req.slot, req.id_in,
                                                 req.type_in, req.bump_sequence, req.now));
      end
      results_owed_o = pending_results.size();
    end
  end

endmodule

// ----- tb/retransmit_window_table_tb.sv -----
// Testbench top: clock, reset, request and response traffic, and the verdict.
`timescale 1ns / 1ps

module retransmit_window_table_tb;
  import rwt_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned PHASE_ITEMS = 280;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [TIMEOUT_W-1:0] cfg_data_i;
  int unsigned          error_count;
  int unsigned          results_owed;

  // Traffic shaping shared by the request and response processes.
  bit no_idle;
  bit hold_rsp_req;

  // Just enough of the table to steer ids and keep bumped deletes on written slots.
  logic [ID_W-1:0]   seq_shadow;
  logic [ID_W-1:0]   id_shadow     [RWT_SLOTS];
  bit                written_shadow[RWT_SLOTS];
  logic [TIME_W-1:0] clock_now;

  rwt_req_if req_ch ();
  rwt_rsp_if rsp_ch ();

  retransmit_window_table uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  retransmit_window_checker table_watch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .error_count_o  (error_count),
    .results_owed_o (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_op(input opcode_e op, input logic [SLOT_W-1:0] s,
                         input logic [ID_W-1:0] id_v, input logic [TYPE_W-1:0] type_v,
                         input logic bump, input logic [TIME_W-1:0] now_v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.slot          <= s;
    req_ch.id_in         <= id_v;
    req_ch.type_in       <= type_v;
    req_ch.bump_sequence <= bump;
    req_ch.now           <= now_v;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    case (op)
      OP_MARK_RECV: begin
        id_shadow[s]      = id_v;
        written_shadow[s] = 1'b1;
      end
      OP_MARK_SENT: begin
        id_shadow[s]      = seq_shadow;
        written_shadow[s] = 1'b1;
        seq_shadow        = seq_shadow + 1;
      end
      OP_DELETE: begin
        if (bump) begin
          seq_shadow = id_shadow[s] + 1;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Ids mostly hit stored ids or sit around the sequence number.
  function automatic logic [ID_W-1:0] choose_id();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, RWT_SLOTS - 1);
    if (pick < 45) begin
      return written_shadow[k] ? id_shadow[k] : seq_shadow;
    end
    if (pick < 65) begin
      return seq_shadow + $urandom_range(0, 3);
    end
    if (pick < 80) begin
      return seq_shadow - $urandom_range(1, 3);
    end
    return $urandom;
  endfunction

  task automatic random_op();
    int unsigned       pick;
    int unsigned       tick;
    opcode_e           op;
    logic [SLOT_W-1:0] s;
    logic              bump;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      op = OP_GET_FREE;
    end else if (pick < 26) begin
      op = OP_MARK_RECV;
    end else if (pick < 42) begin
      op = OP_MARK_SENT;
    end else if (pick < 54) begin
      op = OP_DELETE;
    end else if (pick < 66) begin
      op = OP_PURGE_ACK;
    end else if (pick < 84) begin
      op = OP_SEND_PICK;
    end else if (pick < 90) begin
      op = OP_SCHEDULE_NOW;
    end else begin
      op = OP_GET_SEQUENCED;
    end
    s = SLOT_W'($urandom_range(0, RWT_SLOTS - 1));
    bump = 1'($urandom_range(0, 1));
    if (!written_shadow[s]) begin
      bump = 1'b0;
    end
    // Time mostly creeps forward, sometimes jumps, steps back or nears the wrap.
    tick = $urandom_range(0, 99);
    if (tick < 80) begin
      clock_now = clock_now + $urandom_range(0, 3);
    end else if (tick < 92) begin
      clock_now = clock_now + $urandom_range(4, 70000);
    end else if (tick < 97) begin
      clock_now = $urandom;
    end else begin
      clock_now = 32'hFFFF_FFFF - $urandom_range(0, 4);
    end
    send_op(op, s, choose_id(), TYPE_W'($urandom_range(0, 31)), bump, clock_now);
  endtask

  initial begin : rsp_sink
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall == 0) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        do @(posedge clk_i); while (rsp_ch.valid !== 1'b1);
        repeat (stall - 1) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end
      do @(posedge clk_i); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [TIMEOUT_W-1:0] timeouts[6];
    no_idle      = 1'b0;
    hold_rsp_req = 1'b0;
    seq_shadow   = '0;
    clock_now    = '0;
    for (int i = 0; i < RWT_SLOTS; i++) begin
      id_shadow[i]      = '0;
      written_shadow[i] = 1'b0;
    end
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_data_i           <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_GET_FREE;
    req_ch.slot          <= '0;
    req_ch.id_in         <= '0;
    req_ch.type_in       <= '0;
    req_ch.bump_sequence <= 1'b0;
    req_ch.now           <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the reset value of the retry timeout.
    send_op(OP_GET_FREE,      3'd0, 32'd0,         5'd0,  1'b0, 32'd0);
    send_op(OP_SEND_PICK,     3'd7, 32'd0,         5'd31, 1'b1, 32'd5);
    send_op(OP_MARK_SENT,     3'd0, 32'd0,         5'd31, 1'b0, 32'd10);
    // A received id below the sequence number is stored but stays inactive.
    send_op(OP_MARK_RECV,     3'd1, 32'd0,         5'd0,  1'b0, 32'd10);
    send_op(OP_MARK_RECV,     3'd1, 32'hFFFF_FFFF, 5'd5,  1'b0, 32'd10);
    send_op(OP_MARK_RECV,     3'd2, 32'd1,         5'd1,  1'b0, 32'd11);
    send_op(OP_GET_SEQUENCED, 3'd0, 32'd0,         5'd0,  1'b0, 32'd11);
    send_op(OP_MARK_RECV,     3'd7, 32'd1,         5'd2,  1'b0, 32'd11);
    send_op(OP_SCHEDULE_NOW,  3'd0, 32'd0,         5'd0,  1'b0, 32'd20);
    // Slots two and seven share an id, so the lower index goes first.
    send_op(OP_SEND_PICK,     3'd0, 32'd0,         5'd0,  1'b0, 32'd20);
    send_op(OP_SEND_PICK,     3'd0, 32'd0,         5'd0,  1'b0, 32'd20);
    send_op(OP_SEND_PICK,     3'd0, 32'd0,         5'd0,  1'b0, 32'd21);
    send_op(OP_PURGE_ACK,     3'd0, 32'd1,         5'd0,  1'b0, 32'd21);
    // Bumping from the all-ones id wraps the sequence number to zero.
    send_op(OP_DELETE,        3'd1, 32'd0,         5'd0,  1'b1, 32'd22);
    send_op(OP_MARK_SENT,     3'd3, 32'd0,         5'd9,  1'b0, 32'd22);
    send_op(OP_SCHEDULE_NOW,  3'd0, 32'd0,         5'd0,  1'b0, 32'hFFFF_FFFF);
    send_op(OP_SEND_PICK,     3'd0, 32'd0,         5'd0,  1'b0, 32'hFFFF_FFFF);
    send_op(OP_SEND_PICK,     3'd0, 32'd0,         5'd0,  1'b0, 32'd0);
    for (int k = 1; k < 7; k++) begin
      if (k != 3) begin
        send_op(OP_MARK_SENT, SLOT_W'(k), 32'd0, TYPE_W'(k), 1'b0, 32'd1);
      end
    end
    send_op(OP_GET_FREE,      3'd0, 32'd0,         5'd0,  1'b0, 32'd1);
    // Moving time back far below the next try saturates the wake delay.
    send_op(OP_SCHEDULE_NOW,  3'd0, 32'd0,         5'd0,  1'b0, 32'h0010_0000);
    send_op(OP_SEND_PICK,     3'd0, 32'd0,         5'd0,  1'b0, 32'd0);
    clock_now = 32'd100;

    timeouts[0] = 16'd1;
    timeouts[1] = 16'hFFFF;
    timeouts[2] = 16'd2;
    timeouts[3] = TIMEOUT_W'($urandom_range(1, 65535));
    timeouts[4] = TIMEOUT_W'($urandom_range(1, 32767) << 1);
    timeouts[5] = 16'd3;
    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_timeout(timeouts[p]);
      no_idle = (p == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 100) begin
          hold_rsp_req = 1'b1;
        end
        random_op();
      end
    end

    drain_results();
    repeat (2 * RWT_SLOTS + 8) @(posedge clk_i);
    if (error_count == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
